FILE: hdl/pki_pkg.sv
// ----------------------------------------------------------------------------
// pki_pkg
// Shared types and codes of the piecewise knot interpolator.
// ----------------------------------------------------------------------------
package pki_pkg;

  // result width, Q16.16 signed
  localparam int VALUE_BITS = 32;

  // item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // interpolation modes
  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_STAIR  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  // register indexes
  localparam logic REG_KNOT_COUNT  = 1'b0;
  localparam logic REG_INTERP_MODE = 1'b1;

  typedef struct packed {
    logic               func;
    logic [7:0]         knot_index;
    logic signed [31:0] knot_x;
    logic signed [31:0] knot_y;
    logic signed [31:0] target;
    logic               last_target;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [1:0]                   status;
    logic                         last;
  } res_t;

  typedef struct packed {
    logic [8:0] knot_count;
    logic       interp_mode;
  } cfg_t;

endpackage

FILE: hdl/pki_fifo.sv
// ----------------------------------------------------------------------------
// pki_fifo
// Two-entry queue of words, used between front and back and for results.
// ----------------------------------------------------------------------------
module pki_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

  // word storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

endmodule

FILE: hdl/pki_engine.sv
// ----------------------------------------------------------------------------
// pki_engine
// Back end: knot tables, binary search, multiply, radix-4 divide, saturate.
// ----------------------------------------------------------------------------
module pki_engine #(
  parameter int MAX_KNOTS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pki_pkg::cfg_t     cfg_i,
  input  pki_pkg::in_t      cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  output pki_pkg::res_t     res_o,
  output logic              res_push_o,
  input  logic              res_full_i
);

  localparam int IW = (MAX_KNOTS > 2) ? $clog2(MAX_KNOTS) : 1;
  localparam int NW = IW + 1;
  localparam int VB = pki_pkg::VALUE_BITS;
  localparam logic signed [65:0] VMAX = (66'sd1 <<< (VB - 1)) - 66'sd1;
  localparam logic signed [65:0] VMIN = -VMAX - 66'sd1;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_USE  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // what a table read is for
  localparam logic [2:0] P_HI   = 3'd0;
  localparam logic [2:0] P_LO   = 3'd1;
  localparam logic [2:0] P_BS   = 3'd2;
  localparam logic [2:0] P_FJ   = 3'd3;
  localparam logic [2:0] P_FK   = 3'd4;
  localparam logic [2:0] P_STHI = 3'd5;
  localparam logic [2:0] P_STY  = 3'd6;

  logic [31:0] x_mem [MAX_KNOTS];
  logic [31:0] y_mem [MAX_KNOTS];

  logic [2:0]  state_q, state_d;
  logic [2:0]  phase_q, phase_d;
  logic [IW-1:0] addr_q, addr_d;
  logic [NW-1:0] j_q, j_d, k_q, k_d, n_q, n_d;
  logic signed [31:0] t_q, t_d, rd_x_q, rd_y_q, xj_q, xj_d, base_q, base_d;
  logic        last_q, last_d, mode_q, mode_d, neg_q, neg_d;
  logic [31:0] ma_q, ma_d, mb_q, mb_d, md_q, md_d;
  logic [63:0] div_q, div_d;
  logic [32:0] rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [VB-1:0] value_q, value_d;
  logic [1:0]  st_q, st_d;

  logic        wr_en;
  logic [31:0] idx32, cnt32, n32;
  logic [NW-1:0] n_cl, jn, kn;
  logic [NW:0] lsum;
  logic        go_on;
  logic signed [32:0] da, db, dd;
  logic signed [65:0] sum;
  logic [32:0] r_t;
  logic [63:0] dv_t;

  // knot write decode and count clamp
  assign idx32 = 32'(cmd_i.knot_index);
  assign cnt32 = 32'(cfg_i.knot_count);
  assign n32   = (cnt32 > 32'(MAX_KNOTS)) ? 32'(MAX_KNOTS) : cnt32;
  assign n_cl  = n32[NW-1:0];
  assign cmd_pop_o = (state_q == S_IDLE) && !cmd_empty_i;
  assign wr_en = cmd_pop_o && (cmd_i.func == pki_pkg::FUNC_LOAD) &&
                 (idx32 < 32'(MAX_KNOTS));

  // knot tables, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      x_mem[idx32[IW-1:0]] <= cmd_i.knot_x;
      y_mem[idx32[IW-1:0]] <= cmd_i.knot_y;
    end
    rd_x_q <= x_mem[addr_q];
    rd_y_q <= y_mem[addr_q];
  end

  // segment differences
  assign da = 33'(t_q) - 33'(xj_q);
  assign db = 33'(rd_y_q) - 33'(base_q);
  assign dd = 33'(rd_x_q) - 33'(xj_q);

  // search bracket after this probe
  always_comb begin
    jn = j_q;
    kn = k_q;
    if (phase_q == P_BS) begin
      if (mode_q == pki_pkg::MODE_LINEAR) begin
        if (t_q > rd_x_q) jn = NW'(addr_q);
        else kn = NW'(addr_q);
      end else begin
        if (t_q >= rd_x_q) jn = NW'(addr_q);
        else kn = NW'(addr_q);
      end
    end
    lsum  = {1'b0, jn} + {1'b0, kn};
    go_on = kn > (jn + NW'(1));
  end

  // two restoring divide steps
  always_comb begin
    r_t  = rem_q;
    dv_t = div_q;
    for (int i = 0; i < 2; i++) begin
      r_t  = {r_t[31:0], dv_t[63]};
      dv_t = {dv_t[62:0], 1'b0};
      if (r_t >= {1'b0, md_q}) begin
        r_t = r_t - {1'b0, md_q};
        dv_t[0] = 1'b1;
      end
    end
  end

  assign sum = neg_q ? (66'(base_q) - $signed({2'b00, div_q}))
                     : (66'(base_q) + $signed({2'b00, div_q}));

  // sequencer
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    addr_d  = addr_q;
    j_d = j_q;
    k_d = k_q;
    n_d = n_q;
    t_d = t_q;
    last_d = last_q;
    mode_d = mode_q;
    xj_d = xj_q;
    base_d = base_q;
    neg_d = neg_q;
    ma_d = ma_q;
    mb_d = mb_q;
    md_d = md_q;
    div_d = div_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    value_d = value_q;
    st_d = st_q;
    res_push_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i && cmd_i.func == pki_pkg::FUNC_QUERY) begin
          t_d    = cmd_i.target;
          last_d = cmd_i.last_target;
          mode_d = cfg_i.interp_mode;
          n_d    = n_cl;
          st_d   = pki_pkg::ST_OK;
          value_d = '0;
          if (cfg_i.interp_mode == pki_pkg::MODE_LINEAR) begin
            if (n_cl < NW'(2)) begin
              st_d = pki_pkg::ST_FEW;
              state_d = S_DONE;
            end else begin
              addr_d  = IW'(n_cl - NW'(2));
              phase_d = P_HI;
              state_d = S_RD;
            end
          end else begin
            if (n_cl == '0) begin
              st_d = pki_pkg::ST_FEW;
              state_d = S_DONE;
            end else begin
              addr_d  = IW'(n_cl - NW'(1));
              phase_d = P_STHI;
              state_d = S_RD;
            end
          end
        end
      end
      S_RD: begin
        state_d = S_USE;
      end
      S_USE: begin
        state_d = S_RD;
        case (phase_q)
          P_HI: begin
            if (t_q >= rd_x_q) begin
              j_d = n_q - NW'(2);
              k_d = n_q - NW'(1);
              addr_d = IW'(n_q - NW'(2));
              phase_d = P_FJ;
            end else begin
              addr_d = IW'(1);
              phase_d = P_LO;
            end
          end
          P_LO: begin
            if (t_q <= rd_x_q) begin
              j_d = '0;
              k_d = NW'(1);
              addr_d = '0;
              phase_d = P_FJ;
            end else begin
              j_d = NW'(1);
              k_d = n_q - NW'(2);
              if ((n_q - NW'(2)) > NW'(2)) begin
                addr_d = IW'(({1'b0, NW'(1)} + {1'b0, n_q - NW'(2)}) >> 1);
                phase_d = P_BS;
              end else begin
                addr_d = IW'(1);
                phase_d = P_FJ;
              end
            end
          end
          P_BS: begin
            j_d = jn;
            k_d = kn;
            if (go_on) begin
              addr_d = IW'(lsum >> 1);
            end else begin
              addr_d = IW'(jn);
              phase_d = (mode_q == pki_pkg::MODE_LINEAR) ? P_FJ : P_STY;
            end
          end
          P_STHI: begin
            if (t_q >= rd_x_q) begin
              j_d = n_q - NW'(1);
              addr_d = IW'(n_q - NW'(1));
              phase_d = P_STY;
            end else begin
              j_d = '0;
              k_d = n_q - NW'(1);
              if ((n_q - NW'(1)) > NW'(1)) begin
                addr_d = IW'((n_q - NW'(1)) >> 1);
                phase_d = P_BS;
              end else begin
                addr_d = '0;
                phase_d = P_STY;
              end
            end
          end
          P_FJ: begin
            xj_d = rd_x_q;
            base_d = rd_y_q;
            addr_d = IW'(k_q);
            phase_d = P_FK;
          end
          P_FK: begin
            if (dd == '0) begin
              st_d = pki_pkg::ST_ZERO;
              value_d = '0;
              state_d = S_DONE;
            end else begin
              ma_d = da[32] ? 32'(-da) : da[31:0];
              mb_d = db[32] ? 32'(-db) : db[31:0];
              md_d = dd[32] ? 32'(-dd) : dd[31:0];
              neg_d = da[32] ^ db[32] ^ dd[32];
              state_d = S_MUL;
            end
          end
          P_STY: begin
            base_d = rd_y_q;
            div_d = '0;
            neg_d = 1'b0;
            state_d = S_ADD;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_MUL: begin
        div_d = 64'(ma_q) * 64'(mb_q);
        rem_d = '0;
        cnt_d = '1;
        state_d = S_DIV;
      end
      S_DIV: begin
        div_d = dv_t;
        rem_d = r_t;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) state_d = S_ADD;
      end
      S_ADD: begin
        if (sum > VMAX) begin
          value_d = VB'(VMAX);
          st_d = pki_pkg::ST_SAT;
        end else if (sum < VMIN) begin
          value_d = VB'(VMIN);
          st_d = pki_pkg::ST_SAT;
        end else begin
          value_d = sum[VB-1:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.value  = value_q;
  assign res_o.status = st_q;
  assign res_o.last   = last_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= P_HI;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    j_q <= j_d;
    k_q <= k_d;
    n_q <= n_d;
    t_q <= t_d;
    last_q <= last_d;
    mode_q <= mode_d;
    xj_q <= xj_d;
    base_q <= base_d;
    neg_q <= neg_d;
    ma_q <= ma_d;
    mb_q <= mb_d;
    md_q <= md_d;
    div_q <= div_d;
    rem_q <= rem_d;
    value_q <= value_d;
    st_q <= st_d;
  end

`ifndef SYNTHESIS
  a_push_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> state_q == S_DONE) else $error("result pushed outside done");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q == S_IDLE || state_q == S_RD || state_q == S_DONE))
    else $error("bad state after pop");
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == '0) |=> state_q == S_ADD)
    else $error("divide did not finish");
  a_zero_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && (st_q == pki_pkg::ST_ZERO || st_q == pki_pkg::ST_FEW))
      |-> value_q == '0) else $error("error result not zero");
`endif

endmodule

FILE: hdl/piecewise_knot_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_knot_interpolator
// Knot table with linear or staircase lookup of Q16.16 targets.
// ----------------------------------------------------------------------------
// channel   direction  handshake         word
// input     in         push / full       in_word_i (load knot or query)
// result    out        pop / empty       res_word_o (value, status, last)
// config    in         apb psel/penable  knot_count @0, interp_mode @4
//
// a load is written by the back end when it takes the word while idle; a linear query does
// its table reads (end checks, binary search probes, the two segment knots), 1 multiply,
// a divide with 2 quotient bits per cycle, then the add with saturation.
// reset empties both queues; the knot tables are not cleared.
// input and result queues are two words deep, so each side stalls alone.
// ----------------------------------------------------------------------------
module piecewise_knot_interpolator #(
  parameter int MAX_KNOTS = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  pki_pkg::in_t   in_word_i,
  output logic           empty,
  input  logic           pop,
  output pki_pkg::res_t  res_word_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int IN_W  = $bits(pki_pkg::in_t);
  localparam int RES_W = $bits(pki_pkg::res_t);

  pki_pkg::cfg_t cfg_q;
  pki_pkg::in_t  cmd;
  pki_pkg::res_t res;
  logic [IN_W-1:0]  cmd_bits;
  logic [RES_W-1:0] res_bits;
  logic cmd_empty, cmd_pop, res_push, res_full;
  logic cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.knot_count  <= 9'd2;
      cfg_q.interp_mode <= pki_pkg::MODE_LINEAR;
    end else if (cfg_wr) begin
      if (paddr[2] == pki_pkg::REG_KNOT_COUNT) cfg_q.knot_count <= pwdata[8:0];
      else cfg_q.interp_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == pki_pkg::REG_KNOT_COUNT) ? 32'(cfg_q.knot_count)
                                                        : 32'(cfg_q.interp_mode);

  // front queue of incoming words
  pki_fifo #(.W(IN_W)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (in_word_i),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_bits),
    .empty_o (cmd_empty)
  );

  assign cmd = cmd_bits;

  // back end
  pki_engine #(.MAX_KNOTS(MAX_KNOTS)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // result queue
  pki_fifo #(.W(RES_W)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_bits),
    .empty_o (empty)
  );

  assign res_word_o = res_bits;

endmodule
